// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/mfpr_pkg.sv =====
// Package: command codes, status codes and transaction structs
`timescale 1ns / 1ps
package mfpr_pkg;
    localparam logic [1:0] CMD_PUSH_BYTE  = 2'd0;
    localparam logic [1:0] CMD_PUSH_EMPTY = 2'd1;
    localparam logic [1:0] CMD_POP        = 2'd2;
    localparam logic [1:0] CMD_CLEAR      = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] push_byte;
        logic       push_last;
        logic [6:0] pop_max;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic [6:0]  copied_count;
        logic        message_done;
        logic [6:0]  message_count;
        logic [12:0] stored_bytes;
        logic        queue_empty;
        logic [1:0]  status;
    } out_item_t;
endpackage

// ===== hw/rtl/mfpr_front.sv =====
// Front end: input command queue that decouples accept from execution
`timescale 1ns / 1ps
module mfpr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mfpr_pkg::in_item_t in_item,
    output logic               cmd_valid,
    output mfpr_pkg::in_item_t cmd_item,
    input  logic               cmd_take
);
    mfpr_pkg::in_item_t q_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;
    logic       wr_en, rd_en;

    assign full      = cnt_reg[2];
    assign cmd_valid = (cnt_reg != 3'd0);
    assign cmd_item  = q_reg[rd_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wr_reg <= wr_reg + 2'd1;
            if (rd_en) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, wr_en} - {2'b0, rd_en};
        end
    end
endmodule

// ===== hw/rtl/mfpr_back.sv =====
// Back end: message stores, command execution and result output register
`timescale 1ns / 1ps
module mfpr_back #(
    parameter int DATA_DEPTH    = 4096,
    parameter int MESSAGE_DEPTH = 64,
    parameter int POP_MAX       = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  mfpr_pkg::in_item_t  cmd_item,
    output logic                cmd_take,
    output logic                empty,
    input  logic                pop,
    output mfpr_pkg::out_item_t out_item
);
    localparam int DW = $clog2(DATA_DEPTH);
    localparam int MW = $clog2(MESSAGE_DEPTH);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;   // waiting for length read data
    localparam logic [1:0] S_COPY = 2'd2;

    logic [7:0]  byte_mem [DATA_DEPTH];
    logic [12:0] len_mem  [MESSAGE_DEPTH];

    logic [1:0]    state_reg, state_next;
    logic [MW-1:0] head_reg, tail_reg;
    logic [DW-1:0] rdp_reg, wrp_reg;
    logic [12:0]   off_reg, pend_reg, bytes_reg;
    logic [6:0]    msgs_reg;
    logic [6:0]    copy_reg, idx_reg;
    logic          done_reg;
    logic [12:0]   len_q_reg;
    logic [DW-1:0] addr_reg, addr_next;
    logic [7:0]    rd_data_reg;
    logic          ovalid_reg, ovalid_next;
    mfpr_pkg::out_item_t out_reg, out_next;

    logic out_free;
    logic exec_now, pop_setup, copy_step;
    logic [12:0] len_w, remaining, off_sum;
    logic [6:0]  limit, copy_w;
    logic        msg_full, data_full, push_drop, pop_done;
    logic [DW-1:0] rd_start, rd_addr;

    assign out_free  = !ovalid_reg || pop;
    assign empty     = !ovalid_reg;
    assign out_item  = out_reg;
    // non-pop commands and pops on an empty queue execute straight from idle
    assign exec_now  = (state_reg == S_IDLE) && cmd_valid && out_free
                       && (cmd_item.command != mfpr_pkg::CMD_POP || msgs_reg == 7'd0);
    assign pop_setup = (state_reg == S_READ) && out_free;
    assign copy_step = (state_reg == S_COPY) && out_free;
    assign cmd_take  = exec_now || pop_setup;
    assign msg_full  = ({25'b0, msgs_reg} >= MESSAGE_DEPTH);
    assign data_full = ({19'b0, bytes_reg} + {19'b0, pend_reg} >= DATA_DEPTH);
    assign push_drop = data_full || (cmd_item.push_last && msg_full);

    // pop setup: the head length read arrives in the cycle after the pop is seen (S_READ)
    assign len_w     = len_q_reg;
    assign remaining = (len_w > off_reg) ? len_w - off_reg : 13'd0;
    assign limit     = ({25'b0, cmd_item.pop_max} > POP_MAX) ? 7'(POP_MAX) : cmd_item.pop_max;
    assign copy_w    = (remaining < {6'b0, limit}) ? remaining[6:0] : limit;
    assign off_sum   = off_reg + {6'b0, copy_w};
    assign pop_done  = (off_sum >= len_w);
    assign rd_start  = rdp_reg + off_reg[DW-1:0];
    assign rd_addr   = (state_reg == S_READ) ? rd_start : addr_reg;

    always_ff @(posedge clk)
    begin
        if (exec_now && cmd_item.command == mfpr_pkg::CMD_PUSH_BYTE && !push_drop)
        begin
            byte_mem[wrp_reg] <= cmd_item.push_byte;
        end
        if (exec_now
            && ((cmd_item.command == mfpr_pkg::CMD_PUSH_BYTE && cmd_item.push_last
                 && !push_drop)
                || (cmd_item.command == mfpr_pkg::CMD_PUSH_EMPTY && !msg_full)))
        begin
            len_mem[tail_reg] <= (cmd_item.command == mfpr_pkg::CMD_PUSH_EMPTY)
                                 ? 13'd0 : pend_reg + 13'd1;
        end
        len_q_reg <= len_mem[head_reg];
        // byte read advances only when the streamed byte moves on
        if (pop_setup || copy_step)
        begin
            rd_data_reg <= byte_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (cmd_valid && cmd_item.command == mfpr_pkg::CMD_POP && msgs_reg != 7'd0)
                         state_next = S_READ;
            S_READ:  if (out_free) state_next = (copy_w == 7'd0) ? S_IDLE : S_COPY;
            S_COPY:  if (out_free && idx_reg + 7'd1 == copy_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg && !pop;
        out_next    = out_reg;
        addr_next   = addr_reg;
        if (exec_now)
        begin
            ovalid_next            = 1'b1;
            out_next               = '0;
            out_next.last          = 1'b1;
            out_next.message_count = msgs_reg;
            out_next.stored_bytes  = bytes_reg;
            out_next.queue_empty   = (msgs_reg == 7'd0);
            case (cmd_item.command)
                mfpr_pkg::CMD_PUSH_BYTE:
                begin
                    if (push_drop)
                        out_next.status = mfpr_pkg::ST_FULL;
                    else if (cmd_item.push_last)
                    begin
                        out_next.message_count = msgs_reg + 7'd1;
                        out_next.stored_bytes  = bytes_reg + pend_reg + 13'd1;
                        out_next.queue_empty   = 1'b0;
                    end
                end
                mfpr_pkg::CMD_PUSH_EMPTY:
                begin
                    if (msg_full)
                        out_next.status = mfpr_pkg::ST_FULL;
                    else
                    begin
                        out_next.message_count = msgs_reg + 7'd1;
                        out_next.queue_empty   = 1'b0;
                    end
                end
                mfpr_pkg::CMD_CLEAR:
                begin
                    out_next.message_count = '0;
                    out_next.stored_bytes  = '0;
                    out_next.queue_empty   = 1'b1;
                end
                default: out_next.status = mfpr_pkg::ST_POP_EMPTY;
            endcase
        end
        else if (pop_setup)
        begin
            addr_next = rd_start + 1'b1;
            if (copy_w == 7'd0)
            begin
                ovalid_next            = 1'b1;
                out_next               = '0;
                out_next.last          = 1'b1;
                out_next.message_done  = pop_done;
                out_next.message_count = pop_done ? msgs_reg - 7'd1 : msgs_reg;
                out_next.stored_bytes  = pop_done ? bytes_reg - len_w : bytes_reg;
                out_next.queue_empty   = pop_done && msgs_reg == 7'd1;
            end
        end
        else if (copy_step)
        begin
            ovalid_next            = 1'b1;
            out_next               = '0;
            out_next.out_byte      = rd_data_reg;
            out_next.byte_valid    = 1'b1;
            out_next.copied_count  = idx_reg + 7'd1;
            out_next.last          = (idx_reg + 7'd1 == copy_reg);
            out_next.message_done  = (idx_reg + 7'd1 == copy_reg) && done_reg;
            out_next.message_count = msgs_reg;
            out_next.stored_bytes  = bytes_reg;
            out_next.queue_empty   = (msgs_reg == 7'd0);
            addr_next              = addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            rdp_reg    <= '0;
            wrp_reg    <= '0;
            off_reg    <= '0;
            pend_reg   <= '0;
            bytes_reg  <= '0;
            msgs_reg   <= '0;
            copy_reg   <= '0;
            idx_reg    <= '0;
            done_reg   <= 1'b0;
            addr_reg   <= '0;
            ovalid_reg <= 1'b0;
            out_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            out_reg    <= out_next;
            addr_reg   <= addr_next;
            if (exec_now)
            begin
                case (cmd_item.command)
                    mfpr_pkg::CMD_PUSH_BYTE:
                    begin
                        if (!push_drop)
                        begin
                            wrp_reg <= wrp_reg + 1'b1;
                            if (cmd_item.push_last)
                            begin
                                pend_reg  <= '0;
                                tail_reg  <= tail_reg + 1'b1;
                                msgs_reg  <= msgs_reg + 7'd1;
                                bytes_reg <= bytes_reg + pend_reg + 13'd1;
                            end
                            else
                                pend_reg <= pend_reg + 13'd1;
                        end
                    end
                    mfpr_pkg::CMD_PUSH_EMPTY:
                    begin
                        if (!msg_full)
                        begin
                            tail_reg <= tail_reg + 1'b1;
                            msgs_reg <= msgs_reg + 7'd1;
                        end
                    end
                    mfpr_pkg::CMD_CLEAR:
                    begin
                        head_reg  <= '0;
                        tail_reg  <= '0;
                        rdp_reg   <= '0;
                        wrp_reg   <= '0;
                        off_reg   <= '0;
                        pend_reg  <= '0;
                        bytes_reg <= '0;
                        msgs_reg  <= '0;
                    end
                    default: ;
                endcase
            end
            else if (pop_setup)
            begin
                // commit the pop's state change now; bytes stream afterwards
                copy_reg <= copy_w;
                idx_reg  <= '0;
                done_reg <= pop_done;
                if (pop_done)
                begin
                    rdp_reg   <= rdp_reg + len_w[DW-1:0];
                    head_reg  <= head_reg + 1'b1;
                    msgs_reg  <= msgs_reg - 7'd1;
                    bytes_reg <= bytes_reg - len_w;
                    off_reg   <= '0;
                end
                else
                    off_reg <= off_sum;
            end
            else if (copy_step)
            begin
                idx_reg <= idx_reg + 7'd1;
            end
        end
    end

    // rd_data_reg holds the next byte to stream; the first one is fetched
    // at the setup edge from the head start plus the read offset.
endmodule

// ===== hw/rtl/message_fifo_partial_read.sv =====
// Top level: message FIFO with partial reads
// Usage:
//   Input channel: push/full with a command transaction (push byte, push
//   empty message, pop, clear). A short command queue of four entries sits
//   in front of the execution unit.
//   Result channel: empty/pop; the oldest result is shown while empty is low.
//   Push, push-empty and clear give one result each; it is registered onto
//   the ports once the back end is idle and the output register is free.
//   A pop first reads the head length (S_READ), then sets up and fetches
//   the first byte; a pop that copies nothing shows its single result at
//   setup, otherwise byte results follow in S_COPY, up to POP_MAX results.
//   Throughput while the receiver pops: one non-pop command per cycle,
//   one popped byte per cycle, set by the single byte store read port.
//   Reset clears all pointers and counts; stores need no clearing.
//   When the receiver stalls, the output register holds and the back end
//   waits; the command queue fills and then full goes high.
`timescale 1ns / 1ps
module message_fifo_partial_read #(
    parameter int DATA_DEPTH    = 4096,
    parameter int MESSAGE_DEPTH = 64,
    parameter int POP_MAX       = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mfpr_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output mfpr_pkg::out_item_t out_item
);
    logic               cmd_valid, cmd_take;
    mfpr_pkg::in_item_t cmd_item;

    mfpr_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .cmd_valid(cmd_valid), .cmd_item(cmd_item), .cmd_take(cmd_take)
    );

    mfpr_back #(
        .DATA_DEPTH(DATA_DEPTH), .MESSAGE_DEPTH(MESSAGE_DEPTH), .POP_MAX(POP_MAX)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_item(cmd_item),
        .cmd_take(cmd_take), .empty(empty), .pop(pop), .out_item(out_item)
    );
endmodule

// ===== hw/rtl/mfpr_checker.sv =====
// Port checker for the message FIFO, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mfpr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input mfpr_pkg::out_item_t out_item
);
    logic empty_flag_ok;

    assign empty_flag_ok = (out_item.queue_empty == (out_item.message_count == 7'd0));

    `CHK_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_item), "result moved")
    `CHK_IMPL(a_empty_flag, clk, rst_n, !empty, empty_flag_ok, "queue_empty mismatch")
    `CHK_IMPL(a_done_last, clk, rst_n, !empty && out_item.message_done, out_item.last, "done")
    `CHK_IMPL(a_valid_count, clk, rst_n, !empty && out_item.byte_valid,
              out_item.copied_count != 7'd0, "byte without count")
endmodule

bind message_fifo_partial_read mfpr_checker u_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .out_item(out_item)
);

// ===== bench/message_fifo_partial_read_checker.sv =====
// Checker: predicts message FIFO results and compares them with the result channel
`timescale 1ns / 1ps
module message_fifo_partial_read_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  mfpr_pkg::in_item_t  in_item,
    input  logic                empty,
    input  logic                pop,
    input  mfpr_pkg::out_item_t out_item,
    output int                  error_count,
    output int                  pending_results,
    output int                  result_total,
    output int                  byte_total
);
    localparam int DATA_DEPTH    = 4096;
    localparam int MESSAGE_DEPTH = 64;
    localparam int POP_MAX       = 64;

    logic [7:0]  byte_mem [DATA_DEPTH];
    logic [12:0] len_mem [MESSAGE_DEPTH];
    int unsigned head_idx, tail_idx, rd_base, wr_addr, head_offset;
    int unsigned pending_len, msg_held, bytes_held;

    mfpr_pkg::out_item_t expected_results[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic mfpr_pkg::out_item_t make_result(input logic [7:0] b, input logic v,
                                                        input logic l, input int copied,
                                                        input logic done,
                                                        input logic [1:0] st);
        mfpr_pkg::out_item_t r;
        r.out_byte      = b;
        r.byte_valid    = v;
        r.last          = l;
        r.copied_count  = copied[6:0];
        r.message_done  = done;
        r.message_count = msg_held[6:0];
        r.stored_bytes  = bytes_held[12:0];
        r.queue_empty   = (msg_held == 0);
        r.status        = st;
        return r;
    endfunction

    task automatic commit_message(input int unsigned len);
        len_mem[tail_idx] = len[12:0];
        tail_idx = (tail_idx + 1) % MESSAGE_DEPTH;
        msg_held++;
        bytes_held += len;
    endtask

    task automatic predict_command(input mfpr_pkg::in_item_t t);
        int unsigned len, remaining, limit, ncopy, start;
        logic done;
        logic [7:0] got_bytes [POP_MAX];
        case (t.command)
            mfpr_pkg::CMD_PUSH_BYTE:
            begin
                if (pending_len + bytes_held >= DATA_DEPTH
                    || (t.push_last && msg_held >= MESSAGE_DEPTH))
                    expected_results.push_back(make_result(0, 0, 1, 0, 0, mfpr_pkg::ST_FULL));
                else
                begin
                    byte_mem[wr_addr] = t.push_byte;
                    wr_addr = (wr_addr + 1) % DATA_DEPTH;
                    pending_len++;
                    if (t.push_last)
                    begin
                        commit_message(pending_len);
                        pending_len = 0;
                    end
                    expected_results.push_back(make_result(0, 0, 1, 0, 0, mfpr_pkg::ST_OK));
                end
            end
            mfpr_pkg::CMD_PUSH_EMPTY:
            begin
                if (msg_held >= MESSAGE_DEPTH)
                    expected_results.push_back(make_result(0, 0, 1, 0, 0, mfpr_pkg::ST_FULL));
                else
                begin
                    commit_message(0);
                    expected_results.push_back(make_result(0, 0, 1, 0, 0, mfpr_pkg::ST_OK));
                end
            end
            mfpr_pkg::CMD_CLEAR:
            begin
                head_idx = 0; tail_idx = 0; rd_base = 0; wr_addr = 0;
                head_offset = 0; pending_len = 0; msg_held = 0; bytes_held = 0;
                expected_results.push_back(make_result(0, 0, 1, 0, 0, mfpr_pkg::ST_OK));
            end
            default:
            begin
                if (msg_held == 0)
                    expected_results.push_back(make_result(0, 0, 1, 0, 0,
                                                           mfpr_pkg::ST_POP_EMPTY));
                else
                begin
                    len = len_mem[head_idx];
                    remaining = (len > head_offset) ? len - head_offset : 0;
                    limit = (t.pop_max > POP_MAX) ? POP_MAX : t.pop_max;
                    ncopy = (remaining < limit) ? remaining : limit;
                    start = (rd_base + head_offset) % DATA_DEPTH;
                    for (int i = 0; i < ncopy; i++)
                        got_bytes[i] = byte_mem[(start + i) % DATA_DEPTH];
                    head_offset += ncopy;
                    done = 0;
                    if (head_offset >= len)
                    begin
                        done = 1;
                        rd_base = (rd_base + len) % DATA_DEPTH;
                        head_idx = (head_idx + 1) % MESSAGE_DEPTH;
                        msg_held--;
                        bytes_held -= len;
                        head_offset = 0;
                    end
                    if (ncopy == 0)
                        expected_results.push_back(make_result(0, 0, 1, 0, done,
                                                               mfpr_pkg::ST_OK));
                    for (int i = 0; i < ncopy; i++)
                        expected_results.push_back(make_result(got_bytes[i], 1,
                            i + 1 == ncopy, i + 1, (i + 1 == ncopy) ? done : 1'b0,
                            mfpr_pkg::ST_OK));
                end
            end
        endcase
    endtask

    task automatic compare_result(input mfpr_pkg::out_item_t g);
        mfpr_pkg::out_item_t e;
        if (expected_results.size() == 0)
        begin
            $display("unexpected result transaction at %0t", $realtime);
            error_count++;
            return;
        end
        e = expected_results.pop_front();
        result_total++;
        if (g.byte_valid) byte_total++;
        if (g.out_byte != e.out_byte) report_mismatch("out_byte", g.out_byte, e.out_byte);
        if (g.byte_valid != e.byte_valid)
            report_mismatch("byte_valid", g.byte_valid, e.byte_valid);
        if (g.last != e.last) report_mismatch("last", g.last, e.last);
        if (g.copied_count != e.copied_count)
            report_mismatch("copied_count", g.copied_count, e.copied_count);
        if (g.message_done != e.message_done)
            report_mismatch("message_done", g.message_done, e.message_done);
        if (g.message_count != e.message_count)
            report_mismatch("message_count", g.message_count, e.message_count);
        if (g.stored_bytes != e.stored_bytes)
            report_mismatch("stored_bytes", g.stored_bytes, e.stored_bytes);
        if (g.queue_empty != e.queue_empty)
            report_mismatch("queue_empty", g.queue_empty, e.queue_empty);
        if (g.status != e.status) report_mismatch("status", g.status, e.status);
    endtask

    initial
    begin
        error_count = 0;
        pending_results = 0;
        result_total = 0;
        byte_total = 0;
        head_idx = 0; tail_idx = 0; rd_base = 0; wr_addr = 0;
        head_offset = 0; pending_len = 0; msg_held = 0; bytes_held = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full) predict_command(in_item);
            if (pop && !empty) compare_result(out_item);
            pending_results = expected_results.size();
        end
    end
endmodule

// ===== bench/message_fifo_partial_read_test.sv =====
// Testbench top: stimulus, stalls and verdict for the message FIFO
`timescale 1ns / 1ps
module message_fifo_partial_read_test;
    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    mfpr_pkg::in_item_t  in_item;
    logic                empty;
    logic                pop;
    mfpr_pkg::out_item_t out_item;
    int        error_count, pending_results, result_total, byte_total;
    int        hold_off;
    int        sent_count;

    message_fifo_partial_read DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item)
    );

    message_fifo_partial_read_checker scoreboard (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item), .error_count(error_count),
        .pending_results(pending_results), .result_total(result_total),
        .byte_total(byte_total)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one transaction; random gap before it, held until accepted
    task automatic send_command(input logic [1:0] cmd, input logic [7:0] b,
                                input logic l, input logic [6:0] n);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        in_item <= '{command: cmd, push_byte: b, push_last: l, pop_max: n};
        @(posedge clk);
        while (full) @(posedge clk);
        sent_count++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_command(mfpr_pkg::CMD_PUSH_BYTE, 8'($urandom_range(0, 255)), i == len - 1,
                         7'($urandom_range(0, 127)));
    endtask

    // receiver: random pops, with a forced long hold-off when requested
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                pop <= 1'b0;
                hold_off--;
            end
            else if ($urandom_range(0, 99) < 8)
            begin
                pop <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        #20ms;
        $display("timeout waiting for results");
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int kind, wait_cycles;
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        hold_off = 0;
        sent_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_command(mfpr_pkg::CMD_POP, 8'h00, 1'b0, 7'd5);        // pop on empty queue
        send_command(mfpr_pkg::CMD_PUSH_EMPTY, 8'hFF, 1'b1, 7'h7F);
        send_command(mfpr_pkg::CMD_POP, 8'h00, 1'b0, 7'd0);        // zero-count pop, empty head
        send_command(mfpr_pkg::CMD_PUSH_BYTE, 8'h00, 1'b0, 7'h00);
        send_command(mfpr_pkg::CMD_PUSH_BYTE, 8'hFF, 1'b0, 7'h7F);
        send_command(mfpr_pkg::CMD_PUSH_EMPTY, 8'h55, 1'b0, 7'd0); // empty msg, bytes pending
        send_command(mfpr_pkg::CMD_PUSH_BYTE, 8'hA5, 1'b1, 7'd0);
        send_command(mfpr_pkg::CMD_POP, 8'h00, 1'b0, 7'd1);
        send_command(mfpr_pkg::CMD_POP, 8'h00, 1'b0, 7'd0);        // nothing from nonempty head
        send_command(mfpr_pkg::CMD_POP, 8'h00, 1'b0, 7'd2);
        send_command(mfpr_pkg::CMD_POP, 8'h00, 1'b0, 7'd64);
        send_message(3);
        send_command(mfpr_pkg::CMD_POP, 8'h00, 1'b0, 7'd127);      // count above the pop limit
        send_command(mfpr_pkg::CMD_PUSH_BYTE, 8'h3C, 1'b0, 7'd0);
        send_command(mfpr_pkg::CMD_CLEAR, 8'hFF, 1'b1, 7'h7F);
        send_command(mfpr_pkg::CMD_POP, 8'h00, 1'b0, 7'd1);

        // message store full, then drop a commit; receiver stalled meanwhile
        hold_off = 300;
        for (int m = 0; m < 66; m++)
            send_command(mfpr_pkg::CMD_PUSH_EMPTY, 8'h00, 1'b0, 7'd0);
        send_command(mfpr_pkg::CMD_PUSH_BYTE, 8'h11, 1'b1, 7'd0);
        send_command(mfpr_pkg::CMD_CLEAR, 8'h00, 1'b0, 7'd0);

        // random part: mostly whole messages and pops
        while (sent_count < 330)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45) send_message($urandom_range(1, 12));
            else if (kind < 85)
                send_command(mfpr_pkg::CMD_POP, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)),
                             ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127))
                                                         : 7'($urandom_range(0, 16)));
            else if (kind < 92)
                send_command(mfpr_pkg::CMD_PUSH_EMPTY, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
            else if (kind < 98)
                send_command(mfpr_pkg::CMD_PUSH_BYTE, 8'($urandom_range(0, 255)), 1'b0,
                             7'($urandom_range(0, 127)));
            else
                send_command(mfpr_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
        end
        push <= 1'b0;

        wait_cycles = 0;
        while (pending_results != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        $display("run covered directed corners, a message store full drop and random traffic");
        $display("%0d result transactions checked, %0d of them popped bytes",
                 result_total, byte_total);
        if (error_count == 0 && pending_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mfpr_pkg.sv
hw/rtl/mfpr_front.sv
hw/rtl/mfpr_back.sv
hw/rtl/message_fifo_partial_read.sv
hw/rtl/mfpr_checker.sv
bench/message_fifo_partial_read_checker.sv
bench/message_fifo_partial_read_test.sv
